// ===== rtl/core/lz77d_pkg.sv =====
// Shared types and constants for the LZ77 triple decoder.
`timescale 1ns / 1ps

package lz77d_pkg;

   // Default number of entries in the history ring.
   localparam int HistoryDepthDefault = 256;

   // A triple yields at most this many bytes, the literal included.
   localparam int LookaheadSize = 24;

   // Reset value of the window size register.
   localparam logic [7:0] WindowReset = 8'd226;

   // One input item: an LZ77 triple.
   typedef struct packed {
      logic [7:0] match_start;
      logic [4:0] match_len;
      logic [7:0] literal;
   } lz77d_req_type;

   // One result item: a single decoded byte.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_item;
      logic       bad_reference;
   } lz77d_rsp_type;

   // Sequencer states of the copy engine.
   typedef enum logic [1:0] {
      BkIdle,
      BkCopy,
      BkLit
   } lz77d_back_state_type;

endpackage

// ===== rtl/core/lz77_triple_decoder.sv =====
// Top level of the LZ77 triple decoder: configuration register and block wiring.
`timescale 1ns / 1ps

// Decodes one LZ77 triple (match start, match length, literal) per input item
// into a stream of bytes, one result item per byte: the copied bytes first,
// then the literal, which carries last_of_item. A match length above 23 is
// clipped to 23. A match start at or beyond the usable history (the smaller of
// the bytes written so far, the window size and the ring depth) makes every
// copied byte of that triple come out as zero with bad_reference set. Each
// triple holds the copy engine until its literal is out. It is loaded in the
// idle state, which also starts the history read; the engine then puts out one
// byte per cycle from the history ring while the output register is free. The
// ring has one write and one read port. A front register and a two-entry queue
// take new items while the engine works, and an output register lets the
// engine run until the consumer stalls. The window size register is always
// ready; write it only while the decoder is idle. The history ring needs no
// clearing after reset, so items are accepted from the first cycle.
module lz77_triple_decoder #(
   parameter int HISTORY_DEPTH = lz77d_pkg::HistoryDepthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lz77d_pkg::lz77d_req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lz77d_pkg::lz77d_rsp_type rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_data
);
   import lz77d_pkg::*;

   logic [7:0]    window_ff;
   logic [7:0]    window_in;
   logic          push_valid;
   logic          push_ready;
   lz77d_req_type push_data;
   logic          pop_valid;
   logic          pop_ready;
   lz77d_req_type pop_data;

   // Window size register.
   assign csr_ready = 1'b1;
   assign window_in = (csr_valid && csr_ready) ? csr_data : window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WindowReset;
      end else begin
         window_ff <= window_in;
      end
   end

   lz77d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   lz77d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   lz77d_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .window_size (window_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== rtl/core/lz77d_front.sv =====
// Front end: accepts triples, clips the match length and hands them to the queue.
`timescale 1ns / 1ps

module lz77d_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lz77d_pkg::lz77d_req_type req_data,
   output logic                    push_valid,
   input  logic                    push_ready,
   output lz77d_pkg::lz77d_req_type push_data
);
   import lz77d_pkg::*;

   localparam logic [4:0] MaxCopy = 5'(LookaheadSize - 1);

   logic          valid_ff;
   logic          valid_in;
   lz77d_req_type item_ff;
   lz77d_req_type item_in;
   logic          accept;
   logic          pushed;

   // The holding register frees up in the same cycle its item moves on.
   assign pushed    = valid_ff && push_ready;
   assign req_ready = !valid_ff || push_ready;
   assign accept    = req_valid && req_ready;

   // A copy longer than the lookahead allows is clipped here, once.
   always_comb begin
      item_in = req_data;
      if (32'(req_data.match_len) > LookaheadSize - 1) begin
         item_in.match_len = MaxCopy;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (pushed) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_data  = item_ff;

endmodule

// ===== rtl/core/lz77d_queue.sv =====
// Two-entry queue of triples between the front end and the copy engine.
`timescale 1ns / 1ps

module lz77d_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  lz77d_pkg::lz77d_req_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output lz77d_pkg::lz77d_req_type pop_data
);
   import lz77d_pkg::*;

   lz77d_req_type entry_ff [2];
   logic          wr_ptr_ff;
   logic          wr_ptr_in;
   logic          rd_ptr_ff;
   logic          rd_ptr_in;
   logic [1:0]    count_ff;
   logic [1:0]    count_in;
   logic          do_push;
   logic          do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/lz77d_back.sv =====
// Copy engine: history ring, fill tracking and the byte-by-byte output sequencer.
`timescale 1ns / 1ps

module lz77d_back #(
   parameter int HISTORY_DEPTH = lz77d_pkg::HistoryDepthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              window_size,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  lz77d_pkg::lz77d_req_type pop_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lz77d_pkg::lz77d_rsp_type rsp_data
);
   import lz77d_pkg::*;

   localparam int AddrWidth = $clog2(HISTORY_DEPTH);
   localparam int DiffWidth = ((AddrWidth > 8) ? AddrWidth : 8) + 1;
   localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(HISTORY_DEPTH - 1);
   localparam logic [DiffWidth-1:0] DepthWide = DiffWidth'(HISTORY_DEPTH);

   // History ring; only entries that have been written are used as copy data.
   logic [7:0] history_mem [HISTORY_DEPTH];

   lz77d_back_state_type state_ff;
   lz77d_back_state_type state_in;

   logic [AddrWidth-1:0] wp_ff;
   logic [AddrWidth-1:0] wp_in;
   logic [AddrWidth-1:0] src_ff;
   logic [AddrWidth-1:0] src_in;
   logic [7:0]           filled_ff;
   logic [7:0]           filled_in;
   logic [4:0]           remain_ff;
   logic [4:0]           remain_in;
   logic                 bad_ff;
   logic                 bad_in;
   logic                 near_ff;
   logic                 near_in;
   logic [7:0]           lit_ff;
   logic [7:0]           lit_in;
   logic [7:0]           last_byte_ff;
   logic [7:0]           rd_data_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   lz77d_rsp_type        rsp_ff;
   lz77d_rsp_type        rsp_in;

   logic                 out_free;
   logic                 load;
   logic                 produce;
   logic [7:0]           wr_byte;
   logic [AddrWidth-1:0] rd_addr;
   logic [AddrWidth-1:0] wp_next;
   logic [AddrWidth-1:0] src_next;
   logic [7:0]           eff;
   logic                 start_bad;
   logic [7:0]           src_gap;
   logic [DiffWidth-1:0] wp_wide;
   logic [DiffWidth-1:0] gap_wide;
   logic [AddrWidth-1:0] src_start;

   // The output register can take a byte when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Effective fill at the start of a triple and the copy source it implies.
   always_comb begin
      eff = filled_ff;
      if (eff > window_size) begin
         eff = window_size;
      end
      if (32'(eff) > HISTORY_DEPTH) begin
         eff = 8'(HISTORY_DEPTH);
      end
      start_bad = (pop_data.match_start >= eff);
      src_gap   = eff - pop_data.match_start;
      wp_wide   = DiffWidth'(wp_ff);
      gap_wide  = DiffWidth'(src_gap);
      if (wp_wide >= gap_wide) begin
         src_start = AddrWidth'(wp_wide - gap_wide);
      end else begin
         src_start = AddrWidth'(wp_wide + DepthWide - gap_wide);
      end
   end

   // Ring pointers advance by one with wrap at the history depth.
   assign wp_next  = (wp_ff == LastAddr) ? '0 : wp_ff + 1'b1;
   assign src_next = (src_ff == LastAddr) ? '0 : src_ff + 1'b1;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BkIdle: begin
            if (pop_valid) begin
               state_in = (pop_data.match_len != 5'd0) ? BkCopy : BkLit;
            end
         end
         BkCopy: begin
            if (out_free && remain_ff == 5'd1) begin
               state_in = BkLit;
            end
         end
         BkLit: begin
            if (out_free) begin
               state_in = BkIdle;
            end
         end
         default: begin
            state_in = BkIdle;
         end
      endcase
   end

   // Sequencer outputs: loading a triple, producing a byte, the read address.
   always_comb begin
      load    = 1'b0;
      produce = 1'b0;
      wr_byte = lit_ff;
      rd_addr = src_ff;
      rsp_in  = rsp_ff;
      src_in  = src_ff;
      remain_in = remain_ff;
      bad_in  = bad_ff;
      near_in = near_ff;
      lit_in  = lit_ff;
      case (state_ff)
         BkIdle: begin
            if (pop_valid) begin
               load      = 1'b1;
               src_in    = src_start;
               rd_addr   = src_start;
               remain_in = pop_data.match_len;
               bad_in    = start_bad;
               near_in   = (src_gap == 8'd1);
               lit_in    = pop_data.literal;
            end
         end
         BkCopy: begin
            // A distance of one reads the byte written just before.
            if (bad_ff) begin
               wr_byte = 8'd0;
            end else if (near_ff) begin
               wr_byte = last_byte_ff;
            end else begin
               wr_byte = rd_data_ff;
            end
            if (out_free) begin
               produce   = 1'b1;
               src_in    = src_next;
               rd_addr   = src_next;
               remain_in = remain_ff - 5'd1;
               rsp_in.out_byte      = wr_byte;
               rsp_in.last_of_item  = 1'b0;
               rsp_in.bad_reference = bad_ff;
            end
         end
         BkLit: begin
            wr_byte = lit_ff;
            if (out_free) begin
               produce = 1'b1;
               rsp_in.out_byte      = lit_ff;
               rsp_in.last_of_item  = 1'b1;
               rsp_in.bad_reference = 1'b0;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   assign pop_ready = load;

   // Every produced byte is pushed into the history and counted into the fill.
   always_comb begin
      wp_in        = wp_ff;
      filled_in    = filled_ff;
      rsp_valid_in = rsp_valid_ff;
      if (produce) begin
         wp_in        = wp_next;
         filled_in    = (filled_ff >= window_size) ? window_size : filled_ff + 8'd1;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BkIdle;
         wp_ff        <= '0;
         filled_ff    <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Per-triple working registers and the output payload.
   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      remain_ff <= remain_in;
      bad_ff    <= bad_in;
      near_ff   <= near_in;
      lit_ff    <= lit_in;
      rsp_ff    <= rsp_in;
      if (produce) begin
         last_byte_ff <= wr_byte;
      end
   end

   // History memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (produce) begin
         history_mem[wp_ff] <= wr_byte;
      end
      rd_data_ff <= history_mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the LZ77 triple decoder.
`timescale 1ns / 1ps

module tb;
   import lz77d_pkg::*;

   localparam int HistoryDepth  = HistoryDepthDefault;
   localparam int IdlePercent   = 32;
   localparam int WatchdogLimit = 3000;
   localparam int SettleCycles  = 40;
   localparam int PhaseItems    = 75;

   // Tracks the decoded history and holds the bytes the decoder still owes.
   class lz77_window_scoreboard;
      logic [7:0]    history [HistoryDepth];
      int unsigned   write_pos;
      int unsigned   filled;
      logic [7:0]    window;
      lz77d_rsp_type owed_bytes [$];
      int unsigned   mismatches;
      int unsigned   bytes_checked;
      int unsigned   bad_bytes;
      int unsigned   triples;

      function new();
         write_pos     = 0;
         filled        = 0;
         window        = WindowReset;
         mismatches    = 0;
         bytes_checked = 0;
         bad_bytes     = 0;
         triples       = 0;
      endfunction

      // Usable history: the smallest of fill count, window size and ring depth.
      function int unsigned usable();
         int unsigned eff;
         eff = filled;
         if (eff > window)
            eff = window;
         if (eff > HistoryDepth)
            eff = HistoryDepth;
         return eff;
      endfunction

      function int unsigned pending();
         return owed_bytes.size();
      endfunction

      function void set_window(input logic [7:0] size);
         window = size;
      endfunction

      // Writes one decoded byte into the ring and queues it as an owed result.
      function void push_byte(input logic [7:0] b, input logic last, input logic bad);
         lz77d_rsp_type r;
         history[write_pos] = b;
         write_pos = (write_pos + 1) % HistoryDepth;
         if (filled >= window)
            filled = window;
         else
            filled++;
         r.out_byte      = b;
         r.last_of_item  = last;
         r.bad_reference = bad;
         owed_bytes.insert(owed_bytes.size(), r);
      endfunction

      // Expands one accepted triple into the bytes it decodes to.
      function void note_triple(input lz77d_req_type t);
         int unsigned eff;
         int unsigned len;
         int unsigned src;
         logic        bad;
         logic [7:0]  b;
         eff = usable();
         len = t.match_len;
         if (len > LookaheadSize - 1)
            len = LookaheadSize - 1;
         bad = (t.match_start >= eff);
         triples++;
         for (int unsigned i = 0; i < len; i++) begin
            b = 8'd0;
            if (!bad) begin
               // The source trails the write slot by the distance back from the fill.
               src = (write_pos + HistoryDepth - (eff - t.match_start)) % HistoryDepth;
               b = history[src];
            end
            push_byte(b, 1'b0, bad);
         end
         push_byte(t.literal, 1'b1, 1'b0);
      endfunction

      function void report(input string what, input lz77d_rsp_type exp_r,
                           input lz77d_rsp_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%t: %s: expected byte %h last %b bad %b, got byte %h last %b bad %b",
                     $realtime, what, exp_r.out_byte, exp_r.last_of_item,
                     exp_r.bad_reference, got.out_byte, got.last_of_item,
                     got.bad_reference);
      endfunction

      // Compares one result item with the oldest owed byte, field by field.
      function void check_result(input lz77d_rsp_type got);
         lz77d_rsp_type exp_r;
         if (owed_bytes.size() == 0) begin
            exp_r = '0;
            report("byte with nothing owed", exp_r, got);
            return;
         end
         exp_r = owed_bytes.pop_front();
         bytes_checked++;
         if (exp_r.bad_reference)
            bad_bytes++;
         if (got.out_byte !== exp_r.out_byte || got.last_of_item !== exp_r.last_of_item ||
             got.bad_reference !== exp_r.bad_reference)
            report("byte mismatch", exp_r, got);
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   lz77d_req_type req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   lz77d_rsp_type rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [7:0]    csr_data = 8'd0;

   logic          no_idle = 1'b0;
   int unsigned   quiet_cycles = 0;
   int unsigned   windows_used = 1;
   int unsigned   leftover;

   lz77_window_scoreboard sb;

   lz77_triple_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // The consumer stalls at random except during the no-idle stretch.
   always @(negedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= IdlePercent);
   end

   // Every accepted byte is checked against the predicted stream.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_data);
   end

   // Ends the run when no channel has moved an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("%t: no item moved for %0d cycles", $realtime, quiet_cycles);
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one triple, with random gaps before it; returns at a falling edge.
   task automatic send_triple(input lz77d_req_type t);
      while (!no_idle && $urandom_range(0, 99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_triple(t);
      @(negedge clock);
   endtask

   // Holds the sender until every owed byte has come out, then lets the engine settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_window(input logic [7:0] size);
      csr_valid <= 1'b1;
      csr_data  <= size;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      sb.set_window(size);
      @(negedge clock);
      csr_valid <= 1'b0;
      windows_used++;
   endtask

   function automatic lz77d_req_type make_triple(input int unsigned start,
                                                 input int unsigned len,
                                                 input int unsigned lit);
      lz77d_req_type t;
      t.match_start = 8'(start);
      t.match_len   = 5'(len);
      t.literal     = 8'(lit);
      return t;
   endfunction

   // Mostly references inside the written window, some beyond it, a few long matches.
   function automatic lz77d_req_type random_triple(input int unsigned eff);
      int unsigned start;
      int unsigned len;
      if (eff != 0 && $urandom_range(0, 9) != 0)
         start = $urandom_range(0, eff - 1);
      else
         start = $urandom_range(eff, 255);
      if ($urandom_range(0, 9) == 0)
         len = $urandom_range(24, 31);
      else
         len = $urandom_range(0, 23);
      return make_triple(start, len, $urandom_range(0, 255));
   endfunction

   initial begin
      logic [7:0] phase_windows [6];
      sb = new();
      phase_windows = '{8'd255, 8'd1, 8'd200, 8'd10, 8'd255, 8'd64};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed triples at the reset window size: empty history, literals only,
      // overlapping copies, clipped lengths and references at the window edge.
      send_triple(make_triple(0, 5, 8'h00));
      send_triple(make_triple(0, 0, 8'hFF));
      send_triple(make_triple(0, 0, 8'h5A));
      send_triple(make_triple(0, 1, 8'hA5));
      send_triple(make_triple(sb.usable() - 1, 23, 8'h01));
      send_triple(make_triple(0, 31, 8'h80));
      send_triple(make_triple(255, 4, 8'h7F));
      send_triple(make_triple(sb.usable() - 1, 24, 8'h33));
      send_triple(make_triple(sb.usable(), 3, 8'hCC));
      send_triple(make_triple(0, 23, 8'hC3));
      send_triple(make_triple(sb.usable() - 2, 16, 8'h96));
      send_triple(make_triple(sb.usable() / 2, 8, 8'h69));
      send_triple(make_triple(0, 0, 8'h00));
      send_triple(make_triple(sb.usable() + 1, 31, 8'hFE));
      wait_drained();

      // Random phases, each at its own window size; the 200 to 10 step shrinks
      // the window below the fill count.
      for (int p = 0; p < 6; p++) begin
         write_window(phase_windows[p]);
         no_idle = (p == 4);
         for (int n = 0; n < PhaseItems; n++) begin
            send_triple(random_triple(sb.usable()));
            if (n == PhaseItems / 2 && p == 2)
               wait_drained();
         end
         wait_drained();
      end
      no_idle = 1'b0;

      repeat (SettleCycles) @(posedge clock);
      leftover = sb.pending();
      if (leftover != 0)
         $display("%0d decoded bytes never came out", leftover);

      $display("Decoded %0d triples into %0d checked bytes, %0d of them bad references,",
               sb.triples, sb.bytes_checked, sb.bad_bytes);
      $display("over %0d window settings with random stalls on both sides; %0d mismatches.",
               windows_used, sb.mismatches);
      if (sb.mismatches == 0 && leftover == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
